/* sv/lfr_pkg.sv */
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the letter frequency rank core.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

  // alphabet and field widths
  localparam int unsigned ALPHABET_SIZE = 26;
  localparam int unsigned LETTER_W      = 5;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned OUT_COUNT_W   = 16;
  localparam int unsigned OUT_TDATA_W   = 24;

  // ascii letter bounds
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;

  // last cell and last sort pass / last rank
  localparam logic [LETTER_W-1:0] LAST_IDX = LETTER_W'(ALPHABET_SIZE - 1);

  // per-cell operation
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_COUNT,
    CELL_CMP_RIGHT,
    CELL_CMP_LEFT,
    CELL_SHIFT,
    CELL_LOAD
  } cell_cmd_e;

  // control bundle handed to every cell
  typedef struct packed {
    cell_cmd_e             cmd;
    logic                  hit;
    logic [LETTER_W-1:0]   slot;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/letter_frequency_rank_core.sv */
// ----------------------------------------------------------------------------
// letter_frequency_rank_core
// Case-insensitive letter histogram with a ranked readout, built as a chain
// of 26 cells that count, sort in place and shift out.
// ----------------------------------------------------------------------------
// Text bytes are taken one per cycle; each ASCII letter bumps its saturating
// counter. The transaction flagged with tlast is counted too, after which the
// input stalls: the cell chain runs 26 odd-even compare-and-swap passes,
// then streams out 26 results, highest count first with ties in
// alphabetical order, tlast on the last one. The chain shifts one cell per
// accepted output transaction. On the last output all cells reload a..z with
// zero counts and input resumes in the next cycle. Counts above 65535 report
// as 65535.
`default_nettype none

module letter_frequency_rank_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // [4:0] letter_index, [20:5] letter_count
  output logic             m_axis_tlast    // last_rank
);
  import lfr_pkg::*;

  typedef enum logic [2:0] {
    ST_COUNT = 3'b001,
    ST_SORT  = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [LETTER_W-1:0] step_q, step_d;

  logic                s_fire;
  logic                m_fire;
  logic                byte_hit;
  logic [LETTER_W-1:0] byte_slot;
  logic [OUT_COUNT_W-1:0] out_count;

  logic       [LETTER_W-1:0]    cell_letter [ALPHABET_SIZE];
  logic       [COUNT_WIDTH-1:0] cell_count  [ALPHABET_SIZE];
  cell_ctrl_t                   cell_ctrl   [ALPHABET_SIZE];

  assign s_axis_tready = (state_q == ST_COUNT);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  // letter decode, shared by all cells
  always_comb begin
    byte_hit  = 1'b0;
    byte_slot = '0;
    if ((s_axis_tdata >= CHAR_LOWER_A) && (s_axis_tdata <= CHAR_LOWER_Z)) begin
      byte_hit  = 1'b1;
      byte_slot = LETTER_W'(s_axis_tdata - CHAR_LOWER_A);
    end else if ((s_axis_tdata >= CHAR_UPPER_A) && (s_axis_tdata <= CHAR_UPPER_Z)) begin
      byte_hit  = 1'b1;
      byte_slot = LETTER_W'(s_axis_tdata - CHAR_UPPER_A);
    end
  end

  // sequencer: count, sort passes, readout
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_COUNT: begin
        if (s_fire && s_axis_tlast) begin
          state_d = ST_SORT;
          step_d  = '0;
        end
      end
      ST_SORT: begin
        if (step_q == LAST_IDX) begin
          state_d = ST_EMIT;
          step_d  = '0;
        end else begin
          step_d = step_q + LETTER_W'(1);
        end
      end
      ST_EMIT: begin
        if (m_fire) begin
          if (step_q == LAST_IDX) begin
            state_d = ST_COUNT;
            step_d  = '0;
          end else begin
            step_d = step_q + LETTER_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_COUNT;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // cell chain with per-cell control
  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    localparam logic K_ODD = (k % 2) == 1;
    logic [LETTER_W-1:0]    left_letter, right_letter;
    logic [COUNT_WIDTH-1:0] left_count, right_count;

    if (k == 0) begin : g_head
      assign left_letter = '0;
      assign left_count  = '0;
    end else begin : g_mid_l
      assign left_letter = cell_letter[k-1];
      assign left_count  = cell_count[k-1];
    end
    if (k == ALPHABET_SIZE - 1) begin : g_tail
      assign right_letter = '0;
      assign right_count  = '0;
    end else begin : g_mid_r
      assign right_letter = cell_letter[k+1];
      assign right_count  = cell_count[k+1];
    end

    always_comb begin
      cell_ctrl[k].cmd  = CELL_HOLD;
      cell_ctrl[k].hit  = s_fire && byte_hit;
      cell_ctrl[k].slot = byte_slot;
      case (state_q)
        ST_COUNT: begin
          cell_ctrl[k].cmd = CELL_COUNT;
        end
        ST_SORT: begin
          // pass parity picks whether this cell pairs to the right or left
          if (K_ODD == step_q[0]) begin
            if (k != ALPHABET_SIZE - 1) cell_ctrl[k].cmd = CELL_CMP_RIGHT;
          end else begin
            if (k != 0) cell_ctrl[k].cmd = CELL_CMP_LEFT;
          end
        end
        ST_EMIT: begin
          if (m_fire) begin
            cell_ctrl[k].cmd = (step_q == LAST_IDX) ? CELL_LOAD : CELL_SHIFT;
          end
        end
        default: begin
          cell_ctrl[k].cmd = CELL_HOLD;
        end
      endcase
    end

    lfr_cell #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (cell_ctrl[k]),
      .init_letter_i  (LETTER_W'(k)),
      .left_letter_i  (left_letter),
      .left_count_i   (left_count),
      .right_letter_i (right_letter),
      .right_count_i  (right_count),
      .letter_o       (cell_letter[k]),
      .count_o        (cell_count[k])
    );
  end

  // clamp head count to the output field
  if (COUNT_WIDTH > OUT_COUNT_W) begin : g_clamp
    assign out_count = (|cell_count[0][COUNT_WIDTH-1:OUT_COUNT_W]) ?
                       '1 : cell_count[0][OUT_COUNT_W-1:0];
  end else if (COUNT_WIDTH == OUT_COUNT_W) begin : g_same
    assign out_count = cell_count[0];
  end else begin : g_extend
    assign out_count = {{(OUT_COUNT_W - COUNT_WIDTH){1'b0}}, cell_count[0]};
  end

  // output transaction from the head cell
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_COUNT_W - LETTER_W){1'b0}},
                         out_count, cell_letter[0]};
  assign m_axis_tlast = (step_q == LAST_IDX);

`ifndef SYNTHESIS
  // input and output never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output both active");

  // the final text byte stalls the input
  a_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> !s_axis_tready)
    else $error("input not stalled after end of text");

  // the last result returns the block to counting
  a_last_resumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast) |=> s_axis_tready)
    else $error("input not resumed after readout");

  // while counting the chain is in identity order
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COUNT) |-> ((cell_letter[0] == '0) && (cell_letter[25] == LAST_IDX)))
    else $error("chain not in identity order while counting");
`endif

endmodule

`default_nettype wire

/* sv/lfr_cell.sv */
// ----------------------------------------------------------------------------
// lfr_cell
// One cell of the ranking chain: holds a letter and its count, counts hits,
// compares and swaps with a neighbor, and shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_cell #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lfr_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [lfr_pkg::LETTER_W-1:0] init_letter_i,
  input  wire logic [lfr_pkg::LETTER_W-1:0] left_letter_i,
  input  wire logic [COUNT_WIDTH-1:0]       left_count_i,
  input  wire logic [lfr_pkg::LETTER_W-1:0] right_letter_i,
  input  wire logic [COUNT_WIDTH-1:0]       right_count_i,
  output logic      [lfr_pkg::LETTER_W-1:0] letter_o,
  output logic      [COUNT_WIDTH-1:0]       count_o
);
  import lfr_pkg::*;

  logic [LETTER_W-1:0]    letter_q, letter_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   right_wins;
  logic                   self_wins;

  // ordering: higher count first, lower letter on equal counts
  assign right_wins = (right_count_i > count_q) ||
                      ((right_count_i == count_q) && (right_letter_i < letter_q));
  assign self_wins  = (count_q > left_count_i) ||
                      ((count_q == left_count_i) && (letter_q < left_letter_i));

  // next cell content
  always_comb begin
    letter_d = letter_q;
    count_d  = count_q;
    case (ctrl_i.cmd)
      CELL_HOLD: begin
      end
      CELL_COUNT: begin
        if (ctrl_i.hit && (ctrl_i.slot == letter_q) && !(&count_q)) begin
          count_d = count_q + COUNT_WIDTH'(1);
        end
      end
      CELL_CMP_RIGHT: begin
        if (right_wins) begin
          letter_d = right_letter_i;
          count_d  = right_count_i;
        end
      end
      CELL_CMP_LEFT: begin
        if (self_wins) begin
          letter_d = left_letter_i;
          count_d  = left_count_i;
        end
      end
      CELL_SHIFT: begin
        letter_d = right_letter_i;
        count_d  = right_count_i;
      end
      CELL_LOAD: begin
        letter_d = init_letter_i;
        count_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // cell state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q <= init_letter_i;
      count_q  <= '0;
    end else begin
      letter_q <= letter_d;
      count_q  <= count_d;
    end
  end

  assign letter_o = letter_q;
  assign count_o  = count_q;

endmodule

`default_nettype wire

/* bench/letter_frequency_rank_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_frequency_rank_core_tb
// Self-checking bench for the letter frequency rank core.
// ----------------------------------------------------------------------------
// Text bytes go in on the slave stream; every byte flagged with tlast closes
// a text and must produce 26 ranked results on the master stream. A directed
// table covers letter bounds, non-letters, an empty text, ties and a run of
// one repeated letter; random texts follow under three idle mixes. Every
// output transaction is compared field by field with the oldest expected rank.

module letter_frequency_rank_core_tb;
  import lfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASE_ITEMS  = 30;
  localparam int unsigned SETTLE_TIME  = 60;

  // where the expectation for a closing byte comes from
  typedef enum logic {
    BY_PREDICTOR,
    BY_TABLE
  } check_src_e;

  typedef struct {
    logic [BYTE_W-1:0]      text_byte;
    logic                   end_of_text;
    int unsigned            repeats;
    check_src_e             check_src;
    logic [LETTER_W-1:0]    top_letter;
    logic [OUT_COUNT_W-1:0] top_count;
  } stim_row_t;

  typedef struct {
    logic [LETTER_W-1:0]    letter;
    logic [OUT_COUNT_W-1:0] count;
    logic                   last;
  } rank_entry_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // stream signals
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [7:0] text_byte
  logic                s_axis_tlast  = 1'b0;  // end_of_text
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;   // [4:0] letter_index, [20:5] letter_count
  logic                m_axis_tlast;   // last_rank

  letter_frequency_rank_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predictor state and bookkeeping
  logic [OUT_COUNT_W-1:0] letter_tally [ALPHABET_SIZE];
  rank_entry_t            expected_ranks [$];
  stim_row_t              directed_rows [$];
  int unsigned            tx_idle_pct = 29;
  int unsigned            rx_idle_pct = 45;
  int unsigned            mismatches = 0;
  int unsigned            bytes_sent = 0;
  int unsigned            texts_closed = 0;
  int unsigned            ranks_checked = 0;
  int unsigned            cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // saturating case-insensitive letter count
  task automatic tally_byte(input logic [BYTE_W-1:0] b);
    int slot;
    slot = -1;
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      slot = int'(b - CHAR_LOWER_A);
    end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      slot = int'(b - CHAR_UPPER_A);
    end
    if (slot >= 0 && letter_tally[slot] != '1) begin
      letter_tally[slot] = letter_tally[slot] + 1'b1;
    end
  endtask

  task automatic clear_tally();
    for (int l = 0; l < ALPHABET_SIZE; l++) begin
      letter_tally[l] = '0;
    end
  endtask

  // highest count first, lowest letter wins a tie
  task automatic push_predicted_ranking();
    bit          taken [ALPHABET_SIZE];
    int          best;
    rank_entry_t e;
    for (int l = 0; l < ALPHABET_SIZE; l++) begin
      taken[l] = 1'b0;
    end
    for (int r = 0; r < ALPHABET_SIZE; r++) begin
      best = -1;
      for (int l = 0; l < ALPHABET_SIZE; l++) begin
        if (!taken[l] && (best < 0 || letter_tally[l] > letter_tally[best])) begin
          best = l;
        end
      end
      taken[best] = 1'b1;
      e.letter = LETTER_W'(best);
      e.count  = letter_tally[best];
      e.last   = (r == ALPHABET_SIZE - 1);
      expected_ranks.push_back(e);
    end
  endtask

  // typed expectation: one leading letter, all others zero in a..z order
  task automatic push_table_ranking(input logic [LETTER_W-1:0] top_l,
                                    input logic [OUT_COUNT_W-1:0] top_c);
    rank_entry_t e;
    int          rank;
    e.letter = top_l;
    e.count  = top_c;
    e.last   = 1'b0;
    expected_ranks.push_back(e);
    rank = 1;
    for (int l = 0; l < ALPHABET_SIZE; l++) begin
      if (l != int'(top_l)) begin
        e.letter = LETTER_W'(l);
        e.count  = '0;
        e.last   = (rank == ALPHABET_SIZE - 1);
        expected_ranks.push_back(e);
        rank++;
      end
    end
  endtask

  // drive one byte and wait for its transaction
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot,
                           input check_src_e src, input logic [LETTER_W-1:0] top_l,
                           input logic [OUT_COUNT_W-1:0] top_c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    tally_byte(b);
    if (eot) begin
      if (src == BY_TABLE) begin
        push_table_ranking(top_l, top_c);
      end else begin
        push_predicted_ranking();
      end
      clear_tally();
      texts_closed++;
    end
  endtask

  // hold the sender off until every ranking has been read out
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (expected_ranks.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] random_text_byte();
    logic [LETTER_W-1:0] l;
    if ($urandom_range(99) < 65) begin
      // narrow letter set half the time so ties and big counts show up
      l = $urandom_range(1) ? LETTER_W'($urandom_range(3)) : LETTER_W'($urandom_range(25));
      return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + BYTE_W'(l);
    end
    return BYTE_W'($urandom_range(255));
  endfunction

  // random texts, each closed by a tlast byte
  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    int unsigned phase_items;
    int unsigned len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      len = $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) begin
        send_byte(random_text_byte(), i == len - 1, BY_PREDICTOR, '0, '0);
      end
      phase_items += len;
    end
    drain_outputs();
  endtask

  task automatic add_row(input logic [BYTE_W-1:0] b, input logic eot,
                         input int unsigned reps, input check_src_e src,
                         input logic [LETTER_W-1:0] top_l,
                         input logic [OUT_COUNT_W-1:0] top_c);
    stim_row_t row;
    row.text_byte   = b;
    row.end_of_text = eot;
    row.repeats     = reps;
    row.check_src   = src;
    row.top_letter  = top_l;
    row.top_count   = top_c;
    directed_rows.push_back(row);
  endtask

  // output side: random backpressure and field checks
  initial begin
    rank_entry_t e;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_ranks.size() == 0) begin
          report_mismatch($sformatf("unexpected rank letter %0d count %0d",
                                    m_axis_tdata[4:0], m_axis_tdata[20:5]));
        end else begin
          e = expected_ranks.pop_front();
          if (m_axis_tdata[4:0] !== e.letter) begin
            report_mismatch($sformatf("letter_index expected %0d got %0d",
                                      e.letter, m_axis_tdata[4:0]));
          end
          if (m_axis_tdata[20:5] !== e.count) begin
            report_mismatch($sformatf("letter_count expected %0d got %0d",
                                      e.count, m_axis_tdata[20:5]));
          end
          if (m_axis_tlast !== e.last) begin
            report_mismatch($sformatf("last_rank expected %0b got %0b",
                                      e.last, m_axis_tlast));
          end
          ranks_checked++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d ranks still expected", expected_ranks.size());
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    clear_tally();

    // empty text closed by a non-letter: a..z all zero
    add_row(8'h00, 1'b1, 1, BY_TABLE, 5'd0, 16'd0);
    // letter bounds of both cases and the bytes just outside them
    add_row(8'h41, 1'b0, 1, BY_PREDICTOR, '0, '0);  // A
    add_row(8'h5A, 1'b0, 1, BY_PREDICTOR, '0, '0);  // Z
    add_row(8'h61, 1'b0, 1, BY_PREDICTOR, '0, '0);  // a
    add_row(8'h7A, 1'b0, 1, BY_PREDICTOR, '0, '0);  // z
    add_row(8'h40, 1'b0, 1, BY_PREDICTOR, '0, '0);
    add_row(8'h5B, 1'b0, 1, BY_PREDICTOR, '0, '0);
    add_row(8'h60, 1'b0, 1, BY_PREDICTOR, '0, '0);
    add_row(8'h7B, 1'b0, 1, BY_PREDICTOR, '0, '0);
    add_row(8'hC1, 1'b0, 1, BY_PREDICTOR, '0, '0);  // A with bit 7 set
    add_row(8'hFF, 1'b0, 1, BY_PREDICTOR, '0, '0);
    add_row(8'h7A, 1'b1, 1, BY_PREDICTOR, '0, '0);
    // a single letter as the closing byte is counted
    add_row(8'h6D, 1'b1, 1, BY_TABLE, 5'd12, 16'd1);  // m
    // ties resolve alphabetically
    add_row(8'h63, 1'b0, 2, BY_PREDICTOR, '0, '0);  // c
    add_row(8'h42, 1'b0, 2, BY_PREDICTOR, '0, '0);  // B
    add_row(8'h64, 1'b0, 2, BY_PREDICTOR, '0, '0);  // d
    add_row(8'h20, 1'b1, 1, BY_PREDICTOR, '0, '0);
    // one letter repeated in both cases
    add_row(8'h71, 1'b0, 10, BY_PREDICTOR, '0, '0);  // q
    add_row(8'h51, 1'b1, 1, BY_TABLE, 5'd16, 16'd11);  // Q

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, then random texts under three idle mixes
    foreach (directed_rows[i]) begin
      for (int unsigned n = 0; n < directed_rows[i].repeats; n++) begin
        send_byte(directed_rows[i].text_byte, directed_rows[i].end_of_text,
                  directed_rows[i].check_src, directed_rows[i].top_letter,
                  directed_rows[i].top_count);
      end
    end
    drain_outputs();
    run_random_phase(29, 45);
    run_random_phase(45, 29);
    run_random_phase(0, 0);

    repeat (SETTLE_TIME) @(posedge clk_i);

    $display("covered %0d text bytes in %0d texts, incl. empty and tied ones",
             bytes_sent, texts_closed);
    $display("checked %0d ranked results under three idle mixes, %0d mismatches",
             ranks_checked, mismatches);
    if (mismatches == 0 && expected_ranks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lfr_pkg.sv
sv/lfr_cell.sv
sv/letter_frequency_rank_core.sv
bench/letter_frequency_rank_core_tb.sv
